// ===== hdl/q2e_pkg.sv =====
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared constants and the CORDIC angle table for the quaternion to Euler gate.
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int TABLE_LEN = 24;
  localparam int ANGLE_W   = 26;

  localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 26'sd5898240;
  localparam logic signed [15:0] DEG180 = 16'sd11520;
  localparam logic signed [15:0] DEG90  = 16'sd5760;

  localparam int REG_ROLL_LIMIT  = 0;
  localparam int REG_PITCH_LIMIT = 1;

  function automatic logic signed [ANGLE_W-1:0] angle_tab(input int i);
    logic signed [ANGLE_W-1:0] r;
    case (i)
      0:  r = 26'sd2949120;
      1:  r = 26'sd1740967;
      2:  r = 26'sd919879;
      3:  r = 26'sd466945;
      4:  r = 26'sd234379;
      5:  r = 26'sd117304;
      6:  r = 26'sd58666;
      7:  r = 26'sd29335;
      8:  r = 26'sd14668;
      9:  r = 26'sd7334;
      10: r = 26'sd3667;
      11: r = 26'sd1833;
      12: r = 26'sd917;
      13: r = 26'sd458;
      14: r = 26'sd229;
      15: r = 26'sd115;
      16: r = 26'sd57;
      17: r = 26'sd29;
      18: r = 26'sd14;
      19: r = 26'sd7;
      20: r = 26'sd4;
      21: r = 26'sd2;
      22: r = 26'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/quaternion_to_euler_gate_top.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_gate_top
// Quaternion to roll/pitch/yaw with a limit gate.
// ----------------------------------------------------------------------------
// One quaternion may be started every clock cycle. Each result appears with done
// high for one cycle, after three product and sum stages, one square-root
// stage per root bit (the root stops growing for FRACTION_BITS above 14),
// CORDIC_STEPS+2 stages per CORDIC and the output register. The receiver
// cannot stall; busy is always low. Items whose pitch argument is out of range
// or whose angles fail the limits give no done.
module quaternion_to_euler_gate_top #(
  parameter int CORDIC_STEPS  = 16,
  parameter int FRACTION_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] quat_w,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [13:0]        cfg_data,
  output logic               done,
  output logic signed [14:0] roll_angle,
  output logic signed [13:0] pitch_angle,
  output logic signed [14:0] yaw_angle
);
  import q2e_pkg::*;

  localparam int F2  = 2 * FRACTION_BITS;
  localparam int SH  = (F2 > 28) ? F2 - 28 : 0;
  localparam int PW  = ((F2 > 32) ? F2 : 32) + 4;  // products and sums
  localparam int SW  = F2 - SH + 2;        // shifted s and one
  localparam int RW  = 2 * (F2 - SH) + 2;  // radicand
  localparam int QB  = (RW + 1) / 2;       // root bits
  localparam int CW  = PW;

  logic [13:0] roll_limit, pitch_limit;
  always_ff @(posedge clk) begin
    if (rst) begin
      roll_limit  <= 14'd3520;
      pitch_limit <= 14'd2240;
    end else if (cfg_we) begin
      if (cfg_index == 1'(REG_ROLL_LIMIT)) roll_limit <= cfg_data;
      else pitch_limit <= cfg_data;
    end
  end

  assign busy = 1'b0;

  localparam logic signed [PW-1:0] ONE = PW'(1) <<< F2;

  // stage 1: products
  logic v1;
  logic signed [31:0] pxy, pzw, pyy, pzz, pxw, pyz, pww, pxz, pyw;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= start;
    pxy <= quat_x * quat_y;  pzw <= quat_z * quat_w;
    pyy <= quat_y * quat_y;  pzz <= quat_z * quat_z;
    pxw <= quat_x * quat_w;  pyz <= quat_y * quat_z;
    pww <= quat_w * quat_w;  pxz <= quat_x * quat_z;
    pyw <= quat_y * quat_w;
  end

  // stage 2: sums
  logic v2;
  logic signed [PW-1:0] yaw_y, yaw_x, rol_y, rol_x, sv;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    yaw_y <= (PW'(pxy) + PW'(pzw)) <<< 1;
    yaw_x <= ONE - ((PW'(pyy) + PW'(pzz)) <<< 1);
    rol_y <= (PW'(pxw) + PW'(pyz)) <<< 1;
    rol_x <= ONE - ((PW'(pzz) + PW'(pww)) <<< 1);
    sv    <= (PW'(pxz) - PW'(pyw)) <<< 1;
  end

  // stage 3: range check, shift, square s'
  logic v3, ok3;
  logic signed [PW-1:0] yaw_y3, yaw_x3, rol_y3, rol_x3;
  logic signed [SW-1:0] s3;
  logic [RW-1:0] rad3;
  logic signed [PW-1:0] s_sh;
  logic [SW-1:0] s_mag;
  localparam logic [RW-1:0] ONE2SQ = RW'(1) << (2 * (F2 - SH));
  always_comb begin
    s_sh  = sv >>> SH;
    s_mag = s_sh[SW-1] ? SW'(-s_sh) : SW'(s_sh);
  end
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    ok3 <= (sv <= ONE) && (sv >= -ONE);
    yaw_y3 <= yaw_y; yaw_x3 <= yaw_x; rol_y3 <= rol_y; rol_x3 <= rol_x;
    s3   <= SW'(s_sh);
    rad3 <= ONE2SQ - RW'(s_mag) * RW'(s_mag);
  end

  // integer square root: one result bit per stage
  logic                 qv  [QB+1];
  logic                 qok [QB+1];
  logic [RW-1:0]        qrem[QB+1];
  logic [QB-1:0]        qres[QB+1];
  logic signed [PW-1:0] qyy [QB+1], qyx[QB+1], qry[QB+1], qrx[QB+1];
  logic signed [SW-1:0] qs  [QB+1];
  always_comb begin
    qv[0] = v3; qok[0] = ok3; qrem[0] = rad3; qres[0] = '0;
    qyy[0] = yaw_y3; qyx[0] = yaw_x3; qry[0] = rol_y3; qrx[0] = rol_x3; qs[0] = s3;
  end
  for (genvar k = 0; k < QB; k++) begin : g_sqrt
    localparam int B = QB - 1 - k;
    logic [RW+1:0] trial;
    logic [RW+1:0] remx;
    always_comb begin
      trial = ((RW+2)'(qres[k]) << (B + 1) | ((RW+2)'(1) << (2 * B))) ;
      remx  = (RW+2)'(qrem[k]);
    end
    always_ff @(posedge clk) begin
      if (rst) qv[k+1] <= 1'b0;
      else qv[k+1] <= qv[k];
      qok[k+1] <= qok[k];
      qyy[k+1] <= qyy[k]; qyx[k+1] <= qyx[k];
      qry[k+1] <= qry[k]; qrx[k+1] <= qrx[k]; qs[k+1] <= qs[k];
      if (remx >= trial) begin
        qrem[k+1] <= RW'(remx - trial);
        qres[k+1] <= qres[k] | (QB'(1) << B);
      end else begin
        qrem[k+1] <= qrem[k];
        qres[k+1] <= qres[k];
      end
    end
  end

  // three CORDIC pipes in lockstep
  logic vy, vr, vp;
  logic signed [15:0] yaw_a, rol_a, pit_a;
  q2e_cordic #(.W(CW), .STEPS(CORDIC_STEPS)) u_yaw (
    .clk, .rst, .in_valid(qv[QB] & qok[QB]), .in_y(qyy[QB]), .in_x(qyx[QB]),
    .out_valid(vy), .out_angle(yaw_a));
  q2e_cordic #(.W(CW), .STEPS(CORDIC_STEPS)) u_roll (
    .clk, .rst, .in_valid(qv[QB] & qok[QB]), .in_y(qry[QB]), .in_x(qrx[QB]),
    .out_valid(vr), .out_angle(rol_a));
  q2e_cordic #(.W(CW), .STEPS(CORDIC_STEPS)) u_pitch (
    .clk, .rst, .in_valid(qv[QB] & qok[QB]), .in_y(CW'(qs[QB])),
    .in_x(CW'({1'b0, qres[QB]})), .out_valid(vp), .out_angle(pit_a));

  // remap, clamp, gate
  logic signed [15:0] roll_m, pitch_m, roll_abs, pitch_abs;
  logic pass;
  always_comb begin
    if (rol_a > 0) roll_m = DEG180 - rol_a;
    else roll_m = -rol_a - DEG180;
    pitch_m = -pit_a;
    if (pitch_m > DEG90) pitch_m = DEG90;
    else if (pitch_m < -DEG90) pitch_m = -DEG90;
    roll_abs  = roll_m[15] ? -roll_m : roll_m;
    pitch_abs = pitch_m[15] ? -pitch_m : pitch_m;
    pass = vy & vr & vp && (roll_abs < $signed({2'b00, roll_limit}))
           && (pitch_abs < $signed({2'b00, pitch_limit}));
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= pass;
    roll_angle  <= roll_m[14:0];
    pitch_angle <= pitch_m[13:0];
    yaw_angle   <= yaw_a[14:0];
  end
endmodule

// ===== hdl/q2e_cordic.sv =====
// ----------------------------------------------------------------------------
// q2e_cordic
// Pipelined CORDIC atan2 in vectoring mode, one rotation per register stage,
// output in 1/64 degree clamped to +/-180 degrees; input and output registered.
// ----------------------------------------------------------------------------
module q2e_cordic #(
  parameter int W     = 36,
  parameter int STEPS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic signed [W-1:0] in_y,
  input  logic signed [W-1:0] in_x,
  output logic                out_valid,
  output logic signed [15:0]  out_angle
);
  import q2e_pkg::*;

  localparam int XW = W + 2;

  logic                      vld [STEPS+1];
  logic signed [XW-1:0]      xs  [STEPS+1];
  logic signed [XW-1:0]      ys  [STEPS+1];
  logic signed [ANGLE_W-1:0] zs  [STEPS+1];
  logic                      zro [STEPS+1];

  logic signed [XW-1:0] x0, y0;
  logic signed [ANGLE_W-1:0] z0;

  // pre-rotation by a quarter turn for the left half plane
  always_comb begin
    x0 = XW'(in_x);
    y0 = XW'(in_y);
    z0 = '0;
    if (in_x < 0) begin
      if (in_y >= 0) begin
        x0 = XW'(in_y);
        y0 = -XW'(in_x);
        z0 = QUARTER_TURN;
      end else begin
        x0 = -XW'(in_y);
        y0 = XW'(in_x);
        z0 = -QUARTER_TURN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else vld[0] <= in_valid;
    xs[0]  <= x0;
    ys[0]  <= y0;
    zs[0]  <= z0;
    zro[0] <= (in_x == 0) && (in_y == 0);
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else vld[i+1] <= vld[i];
      zro[i+1] <= zro[i];
      if (ys[i] > 0) begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + angle_tab(i);
      end else begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - angle_tab(i);
      end
    end
  end

  logic signed [ANGLE_W-1:0] zr;
  logic signed [15:0] zc;
  always_comb begin
    zr = (zs[STEPS] + ANGLE_W'(512)) >>> 10;
    if (zr > ANGLE_W'(DEG180)) zc = DEG180;
    else if (zr < -ANGLE_W'(DEG180)) zc = -DEG180;
    else zc = zr[15:0];
    if (zro[STEPS]) zc = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= vld[STEPS];
    out_angle <= zc;
  end
endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the quaternion to roll/pitch/yaw limit gate. Each quaternion
// transfer is run through a local CORDIC model that predicts the gated
// angles. Every done strobe is checked against the oldest prediction. The run
// covers several limit settings and three sender idle rates.
// ----------------------------------------------------------------------------
module tb_top;
  import q2e_pkg::*;

  localparam int  STEPS       = 16;
  localparam int  FRAC        = 14;
  localparam int  LATENCY     = 2 * FRAC + STEPS + 7;
  localparam int  SETTLE      = 2 * LATENCY + 10;
  localparam int  STALL_LIMIT = 5000;
  localparam longint QTURN    = 5898240;
  localparam longint HALF_DEG = 11520;
  localparam longint QTR_DEG  = 5760;
  localparam longint ATAN_STEP [0:15] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115};

  typedef struct packed {
    logic signed [14:0] roll;
    logic signed [13:0] pitch;
    logic signed [14:0] yaw;
  } angles_t;

  class euler_scoreboard;
    angles_t     pending[$];
    int          errors;
    longint      roll_lim;
    longint      pitch_lim;

    function void set_limit(int idx, logic [13:0] val);
      if (idx == REG_ROLL_LIMIT) roll_lim = val;
      else if (idx == REG_PITCH_LIMIT) pitch_lim = val;
    endfunction

    function longint vector_angle(longint yv, longint xv);
      longint xa, ya, za, tx, dx, dy;
      xa = xv; ya = yv; za = 0;
      if (xa == 0 && ya == 0) return 0;
      if (xa < 0) begin
        tx = xa;
        if (ya >= 0) begin
          xa = ya; ya = -tx; za = QTURN;
        end else begin
          xa = -ya; ya = tx; za = -QTURN;
        end
      end
      for (int i = 0; i < STEPS; i++) begin
        dx = ya >>> i;
        dy = xa >>> i;
        if (ya > 0) begin
          xa += dx; ya -= dy; za += ATAN_STEP[i];
        end else begin
          xa -= dx; ya += dy; za -= ATAN_STEP[i];
        end
      end
      return clip((za + 512) >>> 10, HALF_DEG);
    endfunction

    function longint clip(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function longint root_floor(longint unsigned v);
      longint unsigned res, bt;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > v) bt >>= 2;
      while (bt != 0) begin
        if (v >= res + bt) begin
          v -= res + bt;
          res = (res >> 1) + bt;
        end else begin
          res >>= 1;
        end
        bt >>= 2;
      end
      return longint'(res);
    endfunction

    // Predict one quaternion; queue the angles only if it passes the gate.
    function void note_quat(logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z, logic signed [15:0] w);
      longint qx, qy, qz, qw, one, s, yaw, roll, pitch, mag;
      angles_t a;
      qx = x; qy = y; qz = z; qw = w;
      one = 64'sd1 << (2 * FRAC);
      s = 2 * (qx * qz - qy * qw);
      if (s > one || s < -one) return;
      yaw = vector_angle(2 * (qx * qy + qz * qw), one - 2 * (qy * qy + qz * qz));
      roll = vector_angle(2 * (qx * qw + qy * qz), one - 2 * (qz * qz + qw * qw));
      mag = (s < 0) ? -s : s;
      pitch = vector_angle(s, root_floor(one * one - mag * mag));
      roll = (roll > 0) ? HALF_DEG - roll : -roll - HALF_DEG;
      pitch = clip(-pitch, QTR_DEG);
      if (((roll < 0) ? -roll : roll) >= roll_lim) return;
      if (((pitch < 0) ? -pitch : pitch) >= pitch_lim) return;
      a.roll = roll[14:0];
      a.pitch = pitch[13:0];
      a.yaw = yaw[14:0];
      pending.push_back(a);
    endfunction

    function void check_angles(angles_t got);
      angles_t e;
      if (pending.size() == 0) begin
        $error("unexpected result roll=%0d pitch=%0d yaw=%0d",
               got.roll, got.pitch, got.yaw);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.roll !== e.roll) begin
        $error("roll_angle expected %0d actual %0d", e.roll, got.roll);
        errors++;
      end
      if (got.pitch !== e.pitch) begin
        $error("pitch_angle expected %0d actual %0d", e.pitch, got.pitch);
        errors++;
      end
      if (got.yaw !== e.yaw) begin
        $error("yaw_angle expected %0d actual %0d", e.yaw, got.yaw);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] quat_x = '0, quat_y = '0, quat_z = '0, quat_w = '0;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [13:0] cfg_data = '0;
  logic done;
  logic signed [14:0] roll_angle;
  logic signed [13:0] pitch_angle;
  logic signed [14:0] yaw_angle;

  euler_scoreboard sb = new();
  int idle_pct;
  int stall_cycles;

  quaternion_to_euler_gate_top #(.CORDIC_STEPS(STEPS), .FRACTION_BITS(FRAC)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .roll_angle(roll_angle), .pitch_angle(pitch_angle),
    .yaw_angle(yaw_angle)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_quat(quat_x, quat_y, quat_z, quat_w);
      if (done) sb.check_angles('{roll_angle, pitch_angle, yaw_angle});
      if ((start && !busy) || done) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end else begin
      stall_cycles <= 0;
    end
  end

  task automatic send_quat(logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z, logic signed [15:0] w);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    quat_x <= x; quat_y <= y; quat_z <= z; quat_w <= w;
    do @(posedge clk); while (busy);
  endtask

  // Hold off until every prediction is out, then let in-flight drops clear.
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(int idx, logic [13:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx[0:0];
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_limit(idx, val);
  endtask

  function automatic logic signed [15:0] spread(int lo, int hi);
    return 16'(int'($urandom_range(hi - lo)) + lo);
  endfunction

  // Mostly near-level orientations (w dominant) so the gate passes often.
  task automatic send_random;
    int pick;
    logic signed [15:0] w;
    pick = $urandom_range(99);
    if (pick < 20) begin
      send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end else if (pick < 35) begin
      send_quat(spread(-16384, 16384), spread(-16384, 16384),
                spread(-16384, 16384), spread(-16384, 16384));
    end else begin
      w = spread(11000, 16384);
      if ($urandom_range(1)) w = -w;
      send_quat(spread(-6000, 6000), spread(-5000, 5000), spread(-6000, 6000), w);
    end
  endtask

  initial begin
    int lims [0:5][0:1];
    lims = '{'{11520, 11520}, '{0, 0}, '{16383, 16383}, '{3520, 2240},
             '{1, 16383}, '{8000, 600}};
    sb.errors = 0;
    sb.roll_lim = 3520;
    sb.pitch_lim = 2240;
    idle_pct = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset limits, extremes and special cases
    send_quat(0, 0, 0, 16384);
    send_quat(0, 0, 0, -16384);
    send_quat(16384, 0, 0, 0);
    send_quat(0, 0, 0, 0);
    send_quat(16384, 0, 16384, 0);
    send_quat(0, 16384, 0, 16384);
    send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_quat(16'sh8000, 16'sh7fff, 0, 16'sh7fff);
    send_quat(1000, 2000, -1500, 16000);
    send_quat(0, 3000, 0, 16000);
    send_quat(0, 0, 0, -16384);
    drain();
    write_limit(REG_ROLL_LIMIT, 14'd16383);
    write_limit(REG_PITCH_LIMIT, 14'd16383);
    send_quat(-16384, -16384, -16384, -16384);
    send_quat(16384, 16384, 16384, 16384);
    send_quat(0, 11585, 0, 11585);
    send_quat(0, -11585, 0, 11585);
    send_quat(16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(0, 0, 0, 0);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_limit(REG_ROLL_LIMIT, lims[ph][0][13:0]);
      write_limit(REG_PITCH_LIMIT, lims[ph][1][13:0]);
      idle_pct = (ph % 3 == 0) ? 34 : (ph % 3 == 1) ? 61 : 0;
      for (int n = 0; n < 315; n++) send_random();
    end

    drain();
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
